### sv/qlre_pkg.sv
// shared types, widths, codes and reset values of the q-learning timeout estimator
package qlre_pkg;

  // field widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned DelayW  = 24;
  localparam int unsigned AlphaW  = 17;
  localparam int unsigned GammaW  = 18;
  localparam int unsigned BoundW  = 24;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  // shared multiplier: signed 18 x signed 36
  localparam int unsigned MulAW  = 18;
  localparam int unsigned MulBW  = 36;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned FracW  = 16;
  localparam int unsigned RoundW = ProdW - FracW;

  // event codes
  typedef enum logic [ModeW-1:0] {
    MODE_DELAY   = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA_SUCCESS   = 3'd0,
    CFG_ALPHA_FAILURE   = 3'd1,
    CFG_GAMMA_SUCCESS   = 3'd2,
    CFG_GAMMA_FAILURE   = 3'd3,
    CFG_TIMEOUT_FLOOR   = 3'd4,
    CFG_TIMEOUT_CEILING = 3'd5
  } cfg_idx_e;

  // reset values
  localparam logic [AlphaW-1:0]        AlphaSuccessRst = 17'd16384;
  localparam logic [AlphaW-1:0]        AlphaFailureRst = 17'd9830;
  localparam logic signed [GammaW-1:0] GammaSuccessRst = -18'sd32768;
  localparam logic signed [GammaW-1:0] GammaFailureRst = 18'sd492;
  localparam logic [BoundW-1:0]        FloorRst        = 24'd13107;
  localparam logic [BoundW-1:0]        CeilingRst      = 24'd3932160;
  localparam logic signed [ValueW-1:0] OneSecond       = 32'sd65536;

  // channel payloads
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [DelayW-1:0] delay;
  } evt_t;

  typedef struct packed {
    logic [BoundW-1:0]        timeout_value;
    logic signed [ValueW-1:0] estimate;
    logic                     in_failure;
    logic [CountW-1:0]        sample_count;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_t;

endpackage

### sv/qlre_stream_if.sv
// valid/ready channel carrying one payload type
interface qlre_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/qlre_mul.sv
// shared signed multiplier with registered product
module qlre_mul (
  input  logic                                  clk_i,
  input  logic signed [qlre_pkg::MulAW-1:0]     a_i,
  input  logic signed [qlre_pkg::MulBW-1:0]     b_i,
  output logic signed [qlre_pkg::ProdW-1:0]     p_o
);

  logic signed [qlre_pkg::ProdW-1:0] p_q;

  // one product per cycle, operands picked by the sequencer
  always_ff @(posedge clk_i) begin
    p_q <= qlre_pkg::ProdW'(a_i) * qlre_pkg::ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

### sv/qlearning_rto_estimator_unit.sv
// top level of the q-learning retransmission timeout estimator
//
// Channels: evt_i takes one request (mode, delay); res_o returns exactly one
// result per request (timeout_value, estimate, in_failure, sample_count);
// cfg_i writes the six tuning registers by index and is always ready.
// A delay or timeout request runs through one shared 18x36 multiplier twice
// (gamma times the best value, then alpha times the error): the sequencer
// steps through product, error sum, product, update and result, and takes no
// new request before the result is written. A restart or an unused mode skips
// the multiplier and goes straight to the result. evt_i is ready only while
// the sequencer is idle, so one request is handled at a time.
// The result sits in an output register; a new request may be accepted while
// it waits, and the sequencer holds its next result, with evt_i not ready,
// until the receiver has taken the previous one.
// Reset clears both learned values to one second, the state to success, the
// count to zero and the registers to their defaults; nothing waits after it.
module qlearning_rto_estimator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  qlre_stream_if.sink   evt_i,
  qlre_stream_if.source res_o,
  qlre_stream_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD1,
    ST_DIFF,
    ST_PROD2,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [qlre_pkg::AlphaW-1:0]        alpha_s_q, alpha_f_q;
  logic signed [qlre_pkg::GammaW-1:0] gamma_s_q, gamma_f_q;
  logic [qlre_pkg::BoundW-1:0]        floor_q, ceil_q;

  // learner state
  logic signed [qlre_pkg::ValueW-1:0] val_s_q, val_f_q;
  logic                               last_failed_q;
  logic [qlre_pkg::CountW-1:0]        count_q;

  // latched request and intermediate
  logic [qlre_pkg::ModeW-1:0]         mode_q;
  logic [qlre_pkg::DelayW-1:0]        delay_q;
  logic signed [qlre_pkg::MulBW-1:0]  diff_q;
  logic signed [qlre_pkg::MulBW-1:0]  diff_d;

  // result register
  logic             res_valid_q;
  qlre_pkg::res_t   res_q;

  // datapath signals
  logic signed [qlre_pkg::ValueW-1:0]  best, cur, est, new_val;
  logic signed [qlre_pkg::GammaW-1:0]  gamma_sel;
  logic [qlre_pkg::AlphaW-1:0]         alpha_sel;
  logic signed [qlre_pkg::MulAW-1:0]   mul_a;
  logic signed [qlre_pkg::MulBW-1:0]   mul_b;
  logic signed [qlre_pkg::ProdW-1:0]   mul_p, mul_bias;
  logic signed [qlre_pkg::RoundW-1:0]  rnd, upd_sum;
  logic signed [qlre_pkg::ValueW-1:0]  ceil_s, floor_s, tmo_hi, tmo;

  logic evt_fire;

  assign evt_i.ready = (state_q == ST_IDLE);
  assign evt_fire    = evt_i.valid && evt_i.ready;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // operand selection by previous state
  always_comb begin
    best      = (val_s_q > val_f_q) ? val_s_q : val_f_q;
    cur       = last_failed_q ? val_f_q : val_s_q;
    gamma_sel = last_failed_q ? gamma_f_q : gamma_s_q;
    alpha_sel = last_failed_q ? alpha_f_q : alpha_s_q;
    if (state_q == ST_PROD2) begin
      mul_a = $signed({1'b0, alpha_sel});
      mul_b = diff_q;
    end else begin
      mul_a = gamma_sel;
      mul_b = qlre_pkg::MulBW'(best);
    end
  end

  qlre_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // round to q16, error sum, update with saturation
  always_comb begin
    mul_bias = mul_p + qlre_pkg::ProdW'(32768);
    rnd      = mul_bias[qlre_pkg::ProdW-1:qlre_pkg::FracW];
    diff_d   = qlre_pkg::MulBW'(rnd)
             + $signed({{(qlre_pkg::MulBW - qlre_pkg::DelayW){1'b0}}, delay_q})
             - qlre_pkg::MulBW'(cur);
    upd_sum  = qlre_pkg::RoundW'(cur) + rnd;
    if (!upd_sum[qlre_pkg::RoundW-1] &&
        (|upd_sum[qlre_pkg::RoundW-2:qlre_pkg::ValueW-1])) begin
      new_val = {1'b0, {(qlre_pkg::ValueW-1){1'b1}}};
    end else if (upd_sum[qlre_pkg::RoundW-1] &&
                 !(&upd_sum[qlre_pkg::RoundW-2:qlre_pkg::ValueW-1])) begin
      new_val = {1'b1, {(qlre_pkg::ValueW-1){1'b0}}};
    end else begin
      new_val = upd_sum[qlre_pkg::ValueW-1:0];
    end
  end

  // clamp the estimate into the reported timeout, floor wins over ceiling
  always_comb begin
    est     = last_failed_q ? val_f_q : val_s_q;
    ceil_s  = $signed({{(qlre_pkg::ValueW - qlre_pkg::BoundW){1'b0}}, ceil_q});
    floor_s = $signed({{(qlre_pkg::ValueW - qlre_pkg::BoundW){1'b0}}, floor_q});
    tmo_hi  = (est > ceil_s) ? ceil_s : est;
    tmo     = (tmo_hi < floor_s) ? floor_s : tmo_hi;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_s_q <= qlre_pkg::AlphaSuccessRst;
      alpha_f_q <= qlre_pkg::AlphaFailureRst;
      gamma_s_q <= qlre_pkg::GammaSuccessRst;
      gamma_f_q <= qlre_pkg::GammaFailureRst;
      floor_q   <= qlre_pkg::FloorRst;
      ceil_q    <= qlre_pkg::CeilingRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        qlre_pkg::CFG_ALPHA_SUCCESS:   alpha_s_q <= cfg_i.data.data[qlre_pkg::AlphaW-1:0];
        qlre_pkg::CFG_ALPHA_FAILURE:   alpha_f_q <= cfg_i.data.data[qlre_pkg::AlphaW-1:0];
        qlre_pkg::CFG_GAMMA_SUCCESS:   gamma_s_q <= cfg_i.data.data[qlre_pkg::GammaW-1:0];
        qlre_pkg::CFG_GAMMA_FAILURE:   gamma_f_q <= cfg_i.data.data[qlre_pkg::GammaW-1:0];
        qlre_pkg::CFG_TIMEOUT_FLOOR:   floor_q   <= cfg_i.data.data[qlre_pkg::BoundW-1:0];
        qlre_pkg::CFG_TIMEOUT_CEILING: ceil_q    <= cfg_i.data.data[qlre_pkg::BoundW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, learner state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      val_s_q       <= qlre_pkg::OneSecond;
      val_f_q       <= qlre_pkg::OneSecond;
      last_failed_q <= 1'b0;
      count_q       <= '0;
      mode_q        <= '0;
      delay_q       <= '0;
      diff_q        <= '0;
      res_valid_q   <= 1'b0;
      res_q         <= '0;
    end else begin
      // result taken; the result state reloads it itself
      if (res_valid_q && res_o.ready && state_q != ST_RESULT) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (evt_fire) begin
            mode_q  <= evt_i.data.mode;
            delay_q <= evt_i.data.delay;
            if (evt_i.data.mode == qlre_pkg::MODE_DELAY ||
                evt_i.data.mode == qlre_pkg::MODE_TIMEOUT) begin
              state_q <= ST_PROD1;
            end else begin
              if (evt_i.data.mode == qlre_pkg::MODE_RESTART) begin
                val_s_q       <= qlre_pkg::OneSecond;
                val_f_q       <= qlre_pkg::OneSecond;
                last_failed_q <= 1'b0;
                count_q       <= '0;
              end
              state_q <= ST_RESULT;
            end
          end
        end
        ST_PROD1: begin
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_q  <= diff_d;
          state_q <= ST_PROD2;
        end
        ST_PROD2: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (last_failed_q) begin
            val_f_q <= new_val;
          end else begin
            val_s_q <= new_val;
          end
          if (mode_q == qlre_pkg::MODE_DELAY) begin
            last_failed_q <= 1'b0;
            if (count_q != '1) begin
              count_q <= count_q + 1'b1;
            end
          end else begin
            last_failed_q <= 1'b1;
          end
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q         <= 1'b1;
            res_q.timeout_value <= tmo[qlre_pkg::BoundW-1:0];
            res_q.estimate      <= est;
            res_q.in_failure    <= last_failed_q;
            res_q.sample_count  <= count_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
